// ===== src/aopb_pkg.sv =====
// Shared constants, types and a helper function for the alpha-over pixel blend.
package aopb_pkg;

    localparam int CB = 16;                 // component width, Q0.CB
    localparam int IB = 24;                 // pixel index width
    localparam int W2 = 2 * CB;             // product width
    localparam int W2P = W2 + 1;            // sum of two products
    localparam int CFG_IDX_BITS = 3;
    localparam int CH_BITS = 3;

    localparam logic [CB-1:0] ONE = '1;
    localparam logic [CB-1:0] COLOR_RESET = CB'(65535);
    localparam logic [CH_BITS-1:0] CH_RESET = 3'd4;
    localparam logic [CH_BITS-1:0] CH_MAX = 3'd4;
    localparam logic [CH_BITS-1:0] CH_GRAY = 3'd1;

    // Rec.709 luminance weights, scaled to sum to 2^LUM_SHIFT
    localparam int LUM_SHIFT = 16;
    localparam int LUM_PB = CB + LUM_SHIFT;
    localparam int LUM_SB = LUM_PB + 2;
    localparam logic [LUM_SHIFT-1:0] LUM_WR = 16'd13933;
    localparam logic [LUM_SHIFT-1:0] LUM_WG = 16'd46871;
    localparam logic [LUM_SHIFT-1:0] LUM_WB = 16'd4732;

    // divider: quotient bits resolved per pipeline stage
    localparam int DIV_BITS = 2;
    localparam int DIV_STAGES = (CB + DIV_BITS - 1) / DIV_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RED      = 3'd0,
        CFG_GREEN    = 3'd1,
        CFG_BLUE     = 3'd2,
        CFG_ALPHA    = 3'd3,
        CFG_CHANNELS = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [IB-1:0]          idx;
        logic [3:0][CB-1:0]     d;
        logic [CH_BITS-1:0]     ch;
        logic                   wr;
        logic [W2-1:0]          prod;
        logic [CB-1:0]          a;
        logic [CB-1:0]          na;
        logic [CB-1:0]          da;
        logic [CB-1:0]          f;
        logic [CB-1:0]          oa;
        logic [CB-1:0]          g;
        logic [W2-1:0]          lum_a;
        logic [W2-1:0]          d0_na;
        logic [W2-1:0]          dana;
        logic [W2-1:0]          gsum;
        logic [2:0][W2-1:0]     dda;
        logic [2:0][W2-1:0]     ca;
        logic [2:0][W2-1:0]     tna;
        logic [2:0][CB-1:0]     t;
        logic [2:0][CB-1:0]     q;
        logic [2:0][W2P-1:0]    rem;
        logic [2:0]             sat;
    } pipe_t;

    typedef struct packed {
        logic [IB-1:0]      idx;
        logic [3:0][CB-1:0] d;
        logic               wr;
    } out_t;

    // floor(x / ONE) for x <= ONE*ONE: estimate, then one correction step
    function automatic logic [CB-1:0] div_one(input logic [W2-1:0] x);
        logic [W2P-1:0] s;
        logic [CB:0]    q;
        logic [W2P-1:0] back;
        logic [W2P-1:0] r;
        s = {1'b0, x} + W2P'(x[W2-1:CB]);
        q = s[W2P-1:CB];
        back = {q, {CB{1'b0}}} - W2P'(q);
        r = {1'b0, x} - back;
        if (r >= W2P'(ONE)) begin
            q = q + (CB+1)'(1);
        end
        return q[CB-1:0];
    endfunction

endpackage

// ===== src/alpha_over_pixel_blend.sv =====
// Alpha-over pixel blend: pipelined source-over of a fixed color onto a pixel stream.
// Throughput: one pixel per cycle while the skid is free; the restoring divider resolves two quotient bits per stage.
// A one-entry output skid holds a stalled result; the pipeline freezes only when it is full.
// Reset (aresetn low, synchronous) clears all valid bits and the skid and loads register
// defaults; the luminance of the color follows a color write through the product and luminance registers.
module alpha_over_pixel_blend (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [aopb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [aopb_pkg::CB-1:0]            cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [aopb_pkg::IB-1:0]            s_pixel_index,
    input  logic [aopb_pkg::CB-1:0]            s_coverage,
    input  logic [aopb_pkg::CB-1:0]            s_dest_c0,
    input  logic [aopb_pkg::CB-1:0]            s_dest_c1,
    input  logic [aopb_pkg::CB-1:0]            s_dest_c2,
    input  logic [aopb_pkg::CB-1:0]            s_dest_c3,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [aopb_pkg::IB-1:0]            m_pixel_index_out,
    output logic [aopb_pkg::CB-1:0]            m_out_c0,
    output logic [aopb_pkg::CB-1:0]            m_out_c1,
    output logic [aopb_pkg::CB-1:0]            m_out_c2,
    output logic [aopb_pkg::CB-1:0]            m_out_c3,
    output logic                               m_written
);
    import aopb_pkg::*;

    localparam int ST_DIV0 = 8;
    localparam int NST = ST_DIV0 + DIV_STAGES;

    logic [CB-1:0]      color_red_reg;
    logic [CB-1:0]      color_green_reg;
    logic [CB-1:0]      color_blue_reg;
    logic [CB-1:0]      color_alpha_reg;
    logic [CH_BITS-1:0] channel_count_reg;
    logic [2:0][CB-1:0] color_vec;

    logic [2:0][LUM_PB-1:0] lum_prod_reg;
    logic [2:0][LUM_PB-1:0] lum_prod_next;
    logic [CB-1:0]          lum_reg;
    logic [CB-1:0]          lum_next;

    pipe_t            stage_reg  [1:NST];
    pipe_t            stage_next [1:NST];
    logic [NST:1]     valid_reg;
    out_t             skid_reg;
    logic             skid_full_reg;
    out_t             last_out;
    out_t             m_out;
    logic             ce;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_red_reg     <= COLOR_RESET;
            color_green_reg   <= COLOR_RESET;
            color_blue_reg    <= COLOR_RESET;
            color_alpha_reg   <= COLOR_RESET;
            channel_count_reg <= CH_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_RED:      color_red_reg     <= cfg_data;
                CFG_GREEN:    color_green_reg   <= cfg_data;
                CFG_BLUE:     color_blue_reg    <= cfg_data;
                CFG_ALPHA:    color_alpha_reg   <= cfg_data;
                CFG_CHANNELS: channel_count_reg <= cfg_data[CH_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign color_vec = {color_blue_reg, color_green_reg, color_red_reg};

    // luminance of the overlay color, two register stages behind the color
    always_comb begin
        logic [LUM_SB-1:0] lsum;
        lum_prod_next[0] = LUM_PB'(color_red_reg) * LUM_PB'(LUM_WR);
        lum_prod_next[1] = LUM_PB'(color_green_reg) * LUM_PB'(LUM_WG);
        lum_prod_next[2] = LUM_PB'(color_blue_reg) * LUM_PB'(LUM_WB);
        lsum = LUM_SB'(lum_prod_reg[0]) + LUM_SB'(lum_prod_reg[1]) + LUM_SB'(lum_prod_reg[2]);
        if (lsum[LUM_SB-1:LUM_PB] != '0) begin
            lum_next = ONE;
        end else begin
            lum_next = lsum[LUM_PB-1:LUM_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        lum_prod_reg <= lum_prod_next;
        lum_reg      <= lum_next;
    end

    // stage 1: capture, coverage times color alpha
    always_comb begin
        stage_next[1] = '0;
        stage_next[1].idx  = s_pixel_index;
        stage_next[1].d    = {s_dest_c3, s_dest_c2, s_dest_c1, s_dest_c0};
        stage_next[1].ch   = (channel_count_reg > CH_MAX) ? CH_MAX : channel_count_reg;
        stage_next[1].prod = W2'(s_coverage) * W2'(color_alpha_reg);
    end

    // stage 2: effective alpha
    always_comb begin
        stage_next[2] = stage_reg[1];
        stage_next[2].a  = div_one(stage_reg[1].prod);
        stage_next[2].na = ONE - stage_next[2].a;
        stage_next[2].wr = (stage_reg[1].ch != '0) && (stage_next[2].a != '0);
    end

    // stage 3: all first-level products
    always_comb begin
        stage_next[3] = stage_reg[2];
        stage_next[3].da = (stage_reg[2].ch == CH_MAX) ? stage_reg[2].d[3] : ONE;
        stage_next[3].lum_a = W2'(lum_reg) * W2'(stage_reg[2].a);
        stage_next[3].d0_na = W2'(stage_reg[2].d[0]) * W2'(stage_reg[2].na);
        stage_next[3].dana  = W2'(stage_next[3].da) * W2'(stage_reg[2].na);
        for (int k = 0; k < 3; k++) begin
            stage_next[3].dda[k] = W2'(stage_reg[2].d[k]) * W2'(stage_next[3].da);
            stage_next[3].ca[k]  = W2'(color_vec[k]) * W2'(stage_reg[2].a);
        end
    end

    // stage 4: scale back by ONE, sum of the gray terms
    always_comb begin
        stage_next[4] = stage_reg[3];
        stage_next[4].gsum = stage_reg[3].lum_a + stage_reg[3].d0_na;
        stage_next[4].f    = div_one(stage_reg[3].dana);
        for (int k = 0; k < 3; k++) begin
            stage_next[4].t[k] = div_one(stage_reg[3].dda[k]);
        end
    end

    // stage 5: output alpha, gray result, destination term times (ONE - a)
    always_comb begin
        logic [CB:0] oas;
        stage_next[5] = stage_reg[4];
        oas = (CB+1)'(stage_reg[4].a) + (CB+1)'(stage_reg[4].f);
        stage_next[5].oa = oas[CB] ? ONE : oas[CB-1:0];
        stage_next[5].g  = div_one(stage_reg[4].gsum);
        for (int k = 0; k < 3; k++) begin
            stage_next[5].tna[k] = W2'(stage_reg[4].t[k]) * W2'(stage_reg[4].na);
        end
    end

    // stage 6: dividends
    always_comb begin
        stage_next[6] = stage_reg[5];
        for (int k = 0; k < 3; k++) begin
            stage_next[6].rem[k] = W2P'(stage_reg[5].ca[k]) + W2P'(stage_reg[5].tna[k]);
        end
    end

    // stage 7: a quotient of 2^CB or more saturates; otherwise CB quotient bits follow
    always_comb begin
        stage_next[7] = stage_reg[6];
        for (int k = 0; k < 3; k++) begin
            stage_next[7].sat[k] = stage_reg[6].rem[k] >= {1'b0, stage_reg[6].oa, {CB{1'b0}}};
            stage_next[7].q[k]   = '0;
        end
    end

    // restoring divider, DIV_BITS quotient bits per stage, MSB first
    for (genvar gi = 0; gi < DIV_STAGES; gi++) begin : g_div
        always_comb begin
            int bpos;
            logic [W2P-1:0] trial;
            stage_next[ST_DIV0+gi] = stage_reg[ST_DIV0+gi-1];
            for (int b = 0; b < DIV_BITS; b++) begin
                bpos = CB - 1 - gi * DIV_BITS - b;
                if (bpos >= 0) begin
                    for (int k = 0; k < 3; k++) begin
                        trial = W2P'(stage_reg[ST_DIV0+gi-1].oa) << bpos;
                        if (stage_next[ST_DIV0+gi].rem[k] >= trial) begin
                            stage_next[ST_DIV0+gi].rem[k] =
                                stage_next[ST_DIV0+gi].rem[k] - trial;
                            stage_next[ST_DIV0+gi].q[k][bpos] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // last stage: pick blended or passed-through channels
    always_comb begin
        stage_next[NST] = stage_reg[NST-1];
        if (stage_reg[NST-1].wr) begin
            if (stage_reg[NST-1].ch == CH_GRAY) begin
                stage_next[NST].d[0] = stage_reg[NST-1].g;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    if (stage_reg[NST-1].ch > CH_BITS'(k)) begin
                        if (stage_reg[NST-1].oa == '0) begin
                            stage_next[NST].d[k] = '0;
                        end else if (stage_reg[NST-1].sat[k]) begin
                            stage_next[NST].d[k] = ONE;
                        end else begin
                            stage_next[NST].d[k] = stage_reg[NST-1].q[k];
                        end
                    end
                end
                if (stage_reg[NST-1].ch == CH_MAX) begin
                    stage_next[NST].d[3] = stage_reg[NST-1].oa;
                end
            end
        end
    end

    // pipeline advances as long as the skid is free
    assign ce = !skid_full_reg;
    assign s_ready = ce;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 1; i <= NST; i++) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[NST-1:1], s_valid};
        end
    end

    assign last_out.idx = stage_reg[NST].idx;
    assign last_out.d   = stage_reg[NST].d;
    assign last_out.wr  = stage_reg[NST].wr;

    // skid catches the result that a stalled sink did not take
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_ready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (valid_reg[NST] && !m_ready) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_full_reg) begin
            skid_reg <= last_out;
        end
    end

    assign m_out             = skid_full_reg ? skid_reg : last_out;
    assign m_valid           = skid_full_reg || valid_reg[NST];
    assign m_pixel_index_out = m_out.idx;
    assign m_out_c0          = m_out.d[0];
    assign m_out_c1          = m_out.d[1];
    assign m_out_c2          = m_out.d[2];
    assign m_out_c3          = m_out.d[3];
    assign m_written         = m_out.wr;

endmodule

// ===== src/aopb_checker.sv =====
// Port-level assertions for the alpha-over pixel blend, bound to the top level.
module aopb_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [aopb_pkg::IB-1:0]            m_pixel_index_out,
    input logic [aopb_pkg::CB-1:0]            m_out_c0,
    input logic [aopb_pkg::CB-1:0]            m_out_c1,
    input logic [aopb_pkg::CB-1:0]            m_out_c2,
    input logic [aopb_pkg::CB-1:0]            m_out_c3,
    input logic                               m_written
);
    import aopb_pkg::*;

    // reset empties the pipeline and the skid
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result pending or input blocked after reset");

    // input is only blocked while a result is held
    a_block_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input blocked with no result pending");

    // input blocks only after a refused result transfer
    a_block_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input blocked without an output stall");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_index_out)
            && $stable(m_out_c0) && $stable(m_out_c1) && $stable(m_out_c2)
            && $stable(m_out_c3) && $stable(m_written))
        else $error("stalled result changed");

endmodule

bind alpha_over_pixel_blend aopb_checker u_aopb_checker (.*);
